// ----- src/ssh_pkg.sv -----
// shared types, constants and width helpers for the swept sphere hit pipeline
package ssh_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int DIR_W      = 18;
    localparam int LEN_W      = 31;
    localparam int MODE_W     = 2;
    localparam int ROOT_W     = 31;
    localparam int SQ_W       = 2 * ROOT_W;
    localparam int SUM_W      = 64;
    localparam int DIFF_LIM_W = 45;

    // per-component clamp on target minus start
    localparam logic [63:0] DIFF_LIMIT = 64'h0000_0FFF_FFFF_FFFF;

    // mode bit positions
    localparam int MODE_FALLBACK_BIT = 0;
    localparam int MODE_DIST_BIT     = 1;

    // result kinds carried down the pipeline
    localparam logic [1:0] KIND_MISS   = 2'd0;
    localparam logic [1:0] KIND_STATIC = 2'd1;
    localparam logic [1:0] KIND_SWEEP  = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic             dist_mode;
        logic [LEN_W-1:0] proj;
        logic [LEN_W-1:0] len;
    } t_ctx;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // width of the clamped coordinate difference
    function automatic int diff_width(input int coord_w);
        return (coord_w + 1 > DIFF_LIM_W) ? DIFF_LIM_W : coord_w + 1;
    endfunction

endpackage

// ----- src/ssh_front.sv -----
// front stages: difference, dot product, static distance test and path select
module ssh_front import ssh_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_vld,
    input  logic signed [COORD_WIDTH-1:0]               i_start [3],
    input  logic signed [COORD_WIDTH-1:0]               i_target [3],
    input  logic signed [DIR_W-1:0]                     i_dir [3],
    input  logic        [LEN_W-1:0]                     i_len,
    input  logic        [LEN_W-1:0]                     i_radius,
    input  logic        [MODE_W-1:0]                    i_mode,
    output logic                                        o_vld,
    output t_ctx                                        o_ctx,
    output logic signed [diff_width(COORD_WIDTH)-1:0]   o_d [3],
    output logic signed [DIR_W-1:0]                     o_dir [3],
    output logic        [LEN_W-1:0]                     o_radius,
    output logic        [SQ_W-1:0]                      o_rr,
    output logic        [SQ_W-1:0]                      o_sq
);

    localparam int DW  = diff_width(COORD_WIDTH);
    localparam int XW  = max_int(COORD_WIDTH + 1, DIFF_LIM_W);
    localparam int PW0 = DW + DIR_W;
    localparam int PW  = PW0 + 2;
    localparam int CW  = max_int(DW, LEN_W);
    localparam int LW  = LEN_W + FRAC_BITS;
    localparam int GW  = max_int(PW, LW);

    localparam logic signed [XW-1:0] LIM_P = XW'(DIFF_LIMIT);
    localparam logic signed [XW-1:0] LIM_N = -LIM_P;

    // stage a registers
    logic                    r_a_vld;
    logic signed [DW-1:0]    r_a_d [3];
    logic signed [DIR_W-1:0] r_a_dir [3];
    logic [LEN_W-1:0]        r_a_len, r_a_r, r_a_rl;
    logic [MODE_W-1:0]       r_a_mode;
    // stage b registers
    logic                    r_b_vld;
    logic signed [PW0-1:0]   r_b_prod [3];
    logic [LEN_W-1:0]        r_b_dmag [3];
    logic [2:0]              r_b_dok;
    logic [SQ_W-1:0]         r_b_rr;
    logic signed [DW-1:0]    r_b_d [3];
    logic signed [DIR_W-1:0] r_b_dir [3];
    logic [LEN_W-1:0]        r_b_len, r_b_r, r_b_rl;
    logic [MODE_W-1:0]       r_b_mode;
    // stage c registers
    logic                    r_c_vld;
    logic signed [PW-1:0]    r_c_p;
    logic [SQ_W-1:0]         r_c_dsq [3];
    logic [2:0]              r_c_dok;
    logic [SQ_W-1:0]         r_c_rr;
    logic signed [DW-1:0]    r_c_d [3];
    logic signed [DIR_W-1:0] r_c_dir [3];
    logic [LEN_W-1:0]        r_c_len, r_c_r, r_c_rl;
    logic [MODE_W-1:0]       r_c_mode;
    // stage d registers
    logic                    r_d_vld;
    t_ctx                    r_d_ctx;
    logic signed [DW-1:0]    r_d_d [3];
    logic signed [DIR_W-1:0] r_d_dir [3];
    logic [LEN_W-1:0]        r_d_r;
    logic [SQ_W-1:0]         r_d_rr;
    logic [SQ_W-1:0]         r_d_sq;

    // stage a: clamped differences and saturated radius plus length
    logic signed [XW-1:0]    n_a_full [3];
    logic signed [DW-1:0]    n_a_d [3];
    logic [LEN_W:0]          n_a_rlsum;
    logic [LEN_W-1:0]        n_a_rl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_full[i] = XW'((COORD_WIDTH + 1)'(i_target[i]) - (COORD_WIDTH + 1)'(i_start[i]));
            if (n_a_full[i] > LIM_P) begin
                n_a_full[i] = LIM_P;
            end else if (n_a_full[i] < LIM_N) begin
                n_a_full[i] = LIM_N;
            end
            n_a_d[i] = n_a_full[i][DW-1:0];
        end
        n_a_rlsum = {1'b0, i_len} + {1'b0, i_radius};
        n_a_rl    = n_a_rlsum[LEN_W] ? {LEN_W{1'b1}} : n_a_rlsum[LEN_W-1:0];
    end

    // stage b: products, magnitudes, radius square
    logic [DW-1:0]           n_b_mag [3];
    logic [CW-1:0]           n_b_magx [3];
    logic [2:0]              n_b_dok;
    logic [LEN_W-1:0]        n_b_dmag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_mag[i]  = r_a_d[i][DW-1] ? DW'(-r_a_d[i]) : DW'(r_a_d[i]);
            n_b_magx[i] = CW'(n_b_mag[i]);
            n_b_dok[i]  = n_b_magx[i] < CW'(r_a_r);
            n_b_dmag[i] = n_b_magx[i][LEN_W-1:0];
        end
    end

    // stage d: range check, static test and path select
    logic [GW-1:0]           n_d_pu;
    logic [GW-1:0]           n_d_pq;
    logic                    n_d_oor;
    logic [SUM_W-1:0]        n_d_ssum;
    logic                    n_d_shit;
    t_ctx                    n_d_ctx;

    always_comb begin
        n_d_pu   = GW'($unsigned(r_c_p));
        n_d_pq   = n_d_pu >> FRAC_BITS;
        n_d_oor  = r_c_p[PW-1] || (n_d_pu > GW'({r_c_rl, {FRAC_BITS{1'b0}}}));
        n_d_ssum = SUM_W'(r_c_dsq[0]) + SUM_W'(r_c_dsq[1]) + SUM_W'(r_c_dsq[2]);
        n_d_shit = (&r_c_dok) && (n_d_ssum < SUM_W'(r_c_rr));
        n_d_ctx.dist_mode = r_c_mode[MODE_DIST_BIT];
        n_d_ctx.proj      = n_d_pq[LEN_W-1:0];
        n_d_ctx.len       = r_c_len;
        if (r_c_len == '0 || (n_d_oor && r_c_mode[MODE_FALLBACK_BIT])) begin
            n_d_ctx.kind = n_d_shit ? KIND_STATIC : KIND_MISS;
        end else if (n_d_oor) begin
            n_d_ctx.kind = KIND_MISS;
        end else begin
            n_d_ctx.kind = KIND_SWEEP;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_d[i]    <= n_a_d[i];
            r_a_dir[i]  <= i_dir[i];
            r_b_prod[i] <= PW0'(r_a_d[i]) * PW0'(r_a_dir[i]);
            r_b_dmag[i] <= n_b_dmag[i];
            r_b_d[i]    <= r_a_d[i];
            r_b_dir[i]  <= r_a_dir[i];
            r_c_dsq[i]  <= SQ_W'(r_b_dmag[i]) * SQ_W'(r_b_dmag[i]);
            r_c_d[i]    <= r_b_d[i];
            r_c_dir[i]  <= r_b_dir[i];
            r_d_d[i]    <= r_c_d[i];
            r_d_dir[i]  <= r_c_dir[i];
        end
        r_a_len  <= i_len;
        r_a_r    <= i_radius;
        r_a_rl   <= n_a_rl;
        r_a_mode <= i_mode;
        r_b_dok  <= n_b_dok;
        r_b_rr   <= SQ_W'(r_a_r) * SQ_W'(r_a_r);
        r_b_len  <= r_a_len;
        r_b_r    <= r_a_r;
        r_b_rl   <= r_a_rl;
        r_b_mode <= r_a_mode;
        r_c_p    <= PW'(r_b_prod[0]) + PW'(r_b_prod[1]) + PW'(r_b_prod[2]);
        r_c_dok  <= r_b_dok;
        r_c_rr   <= r_b_rr;
        r_c_len  <= r_b_len;
        r_c_r    <= r_b_r;
        r_c_rl   <= r_b_rl;
        r_c_mode <= r_b_mode;
        r_d_ctx  <= n_d_ctx;
        r_d_r    <= r_c_r;
        r_d_rr   <= r_c_rr;
        r_d_sq   <= n_d_ssum[SQ_W-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    assign o_vld    = r_d_vld;
    assign o_ctx    = r_d_ctx;
    assign o_d      = r_d_d;
    assign o_dir    = r_d_dir;
    assign o_radius = r_d_r;
    assign o_rr     = r_d_rr;
    assign o_sq     = r_d_sq;

endmodule

// ----- src/ssh_miss.sv -----
// sweep stages: closest point offset, miss distance test, root operand select
module ssh_miss import ssh_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_vld,
    input  t_ctx                                        i_ctx,
    input  logic signed [diff_width(COORD_WIDTH)-1:0]   i_d [3],
    input  logic signed [DIR_W-1:0]                     i_dir [3],
    input  logic        [LEN_W-1:0]                     i_radius,
    input  logic        [SQ_W-1:0]                      i_rr,
    input  logic        [SQ_W-1:0]                      i_sq,
    output logic                                        o_vld,
    output t_ctx                                        o_ctx,
    output logic        [SQ_W-1:0]                      o_op
);

    localparam int DW  = diff_width(COORD_WIDTH);
    localparam int PRW = DIR_W + LEN_W + 1;
    localparam int SHW = PRW - FRAC_BITS;
    localparam int MW  = max_int(DW, SHW + 1) + 1;
    localparam int CW  = max_int(MW, LEN_W);

    // stage e
    logic                   r_e_vld;
    t_ctx                   r_e_ctx;
    logic signed [PRW-1:0]  r_e_prod [3];
    logic signed [DW-1:0]   r_e_d [3];
    logic [LEN_W-1:0]       r_e_r;
    logic [SQ_W-1:0]        r_e_rr, r_e_sq;
    // stage f
    logic                   r_f_vld;
    t_ctx                   r_f_ctx;
    logic signed [MW-1:0]   r_f_m [3];
    logic [LEN_W-1:0]       r_f_r;
    logic [SQ_W-1:0]        r_f_rr, r_f_sq;
    // stage g
    logic                   r_g_vld;
    t_ctx                   r_g_ctx;
    logic [SQ_W-1:0]        r_g_msq [3];
    logic [2:0]             r_g_mok;
    logic [SQ_W-1:0]        r_g_rr, r_g_sq;
    // stage h
    logic                   r_h_vld;
    t_ctx                   r_h_ctx;
    logic [SQ_W-1:0]        r_h_op;

    // stage f: offset from the closest point on the ray to the target
    logic [PRW-1:0]         n_f_pmag [3];
    logic [SHW-1:0]         n_f_sh [3];
    logic signed [MW-1:0]   n_f_m [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f_pmag[i] = r_e_prod[i][PRW-1] ? PRW'(-r_e_prod[i]) : PRW'(r_e_prod[i]);
            n_f_sh[i]   = SHW'(n_f_pmag[i] >> FRAC_BITS);
            if (r_e_prod[i][PRW-1]) begin
                n_f_m[i] = MW'(r_e_d[i]) + $signed(MW'(n_f_sh[i]));
            end else begin
                n_f_m[i] = MW'(r_e_d[i]) - $signed(MW'(n_f_sh[i]));
            end
        end
    end

    // stage g: magnitudes against the contact radius
    logic [MW-1:0]          n_g_mag [3];
    logic [CW-1:0]          n_g_magx [3];
    logic [2:0]             n_g_mok;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_g_mag[i]  = r_f_m[i][MW-1] ? MW'(-r_f_m[i]) : MW'(r_f_m[i]);
            n_g_magx[i] = CW'(n_g_mag[i]);
            n_g_mok[i]  = n_g_magx[i] < CW'(r_f_r);
        end
    end

    // stage h: miss test and square root operand
    logic [SUM_W-1:0]       n_h_sum;
    logic                   n_h_in;
    t_ctx                   n_h_ctx;
    logic [SQ_W-1:0]        n_h_op;

    always_comb begin
        n_h_sum = SUM_W'(r_g_msq[0]) + SUM_W'(r_g_msq[1]) + SUM_W'(r_g_msq[2]);
        n_h_in  = (&r_g_mok) && (n_h_sum < SUM_W'(r_g_rr));
        n_h_ctx = r_g_ctx;
        n_h_op  = r_g_sq;
        if (r_g_ctx.kind == KIND_SWEEP) begin
            n_h_op = r_g_rr - n_h_sum[SQ_W-1:0];
            if (!n_h_in) begin
                n_h_ctx.kind = KIND_MISS;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e_prod[i] <= PRW'(i_dir[i]) * $signed(PRW'(i_ctx.proj));
            r_e_d[i]    <= i_d[i];
            r_f_m[i]    <= n_f_m[i];
            r_g_msq[i]  <= SQ_W'(n_g_magx[i][LEN_W-1:0]) * SQ_W'(n_g_magx[i][LEN_W-1:0]);
        end
        r_e_ctx <= i_ctx;
        r_e_r   <= i_radius;
        r_e_rr  <= i_rr;
        r_e_sq  <= i_sq;
        r_f_ctx <= r_e_ctx;
        r_f_r   <= r_e_r;
        r_f_rr  <= r_e_rr;
        r_f_sq  <= r_e_sq;
        r_g_ctx <= r_f_ctx;
        r_g_mok <= n_g_mok;
        r_g_rr  <= r_f_rr;
        r_g_sq  <= r_f_sq;
        r_h_ctx <= n_h_ctx;
        r_h_op  <= n_h_op;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else begin
            r_e_vld <= i_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    assign o_vld = r_h_vld;
    assign o_ctx = r_h_ctx;
    assign o_op  = r_h_op;

endmodule

// ----- src/ssh_isqrt.sv -----
// pipelined floor square root, one result bit per stage
module ssh_isqrt import ssh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_ctx              i_ctx,
    input  logic [SQ_W-1:0]   i_op,
    output logic              o_vld,
    output t_ctx              o_ctx,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 2;

    logic              r_vld  [ROOT_W];
    t_ctx              r_ctx  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SQ_W-1:0]   r_op   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              vld_in;
        t_ctx              ctx_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   op_in;
        logic [REM_W+1:0]  n_rem2;
        logic [REM_W+1:0]  n_trial;
        logic              n_take;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign ctx_in  = i_ctx;
            assign rem_in  = '0;
            assign root_in = '0;
            assign op_in   = i_op;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign ctx_in  = r_ctx[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign op_in   = r_op[k-1];
        end

        // bring down two operand bits, try root*4+1
        assign n_rem2  = {rem_in, op_in[SQ_W-1 -: 2]};
        assign n_trial = (REM_W + 2)'({root_in, 2'b01});
        assign n_take  = n_rem2 >= n_trial;

        always_ff @(posedge i_clk) begin
            r_ctx[k]  <= ctx_in;
            r_op[k]   <= op_in << 2;
            r_rem[k]  <= n_take ? REM_W'(n_rem2 - n_trial) : REM_W'(n_rem2);
            r_root[k] <= {root_in[ROOT_W-2:0], n_take};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_ctx  = r_ctx[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];

endmodule

// ----- src/swept_sphere_sphere_hit.sv -----
// swept sphere against sphere hit test, top level with result register
// pipeline: an accepted query passes through these registered stages in order
// (4 front stages, 4 sweep stages, 31 square root stages, 1 result register)
// throughput: one query per cycle, set by the fully pipelined datapath; busy stays low
// each result is strobed for one cycle and the receiver cannot stall the pipeline
// reset: synchronous active low, clears all valid bits so no stale strobe appears
module swept_sphere_sphere_hit import ssh_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [DIR_W-1:0]       i_dir_x,
    input  logic signed [DIR_W-1:0]       i_dir_y,
    input  logic signed [DIR_W-1:0]       i_dir_z,
    input  logic        [LEN_W-1:0]       i_move_length,
    input  logic        [LEN_W-1:0]       i_contact_radius,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    input  logic        [MODE_W-1:0]      i_mode,
    output logic                          o_strobe,
    output logic                          o_hit,
    output logic        [LEN_W-1:0]       o_hit_distance
);

    localparam int DW = diff_width(COORD_WIDTH);

    logic signed [COORD_WIDTH-1:0] w_start [3];
    logic signed [COORD_WIDTH-1:0] w_target [3];
    logic signed [DIR_W-1:0]       w_dir [3];

    logic                          w_f_vld;
    t_ctx                          w_f_ctx;
    logic signed [DW-1:0]          w_f_d [3];
    logic signed [DIR_W-1:0]       w_f_dir [3];
    logic [LEN_W-1:0]              w_f_r;
    logic [SQ_W-1:0]               w_f_rr, w_f_sq;

    logic                          w_m_vld;
    t_ctx                          w_m_ctx;
    logic [SQ_W-1:0]               w_m_op;

    logic                          w_s_vld;
    t_ctx                          w_s_ctx;
    logic [ROOT_W-1:0]             w_s_root;

    logic                          r_strobe;
    logic                          r_hit;
    logic [LEN_W-1:0]              r_dist;

    // every cycle takes a transfer
    assign busy = 1'b0;

    assign w_start[0]  = i_start_x;
    assign w_start[1]  = i_start_y;
    assign w_start[2]  = i_start_z;
    assign w_target[0] = i_target_x;
    assign w_target[1] = i_target_y;
    assign w_target[2] = i_target_z;
    assign w_dir[0]    = i_dir_x;
    assign w_dir[1]    = i_dir_y;
    assign w_dir[2]    = i_dir_z;

    ssh_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (start && !busy),
        .i_start  (w_start),
        .i_target (w_target),
        .i_dir    (w_dir),
        .i_len    (i_move_length),
        .i_radius (i_contact_radius),
        .i_mode   (i_mode),
        .o_vld    (w_f_vld),
        .o_ctx    (w_f_ctx),
        .o_d      (w_f_d),
        .o_dir    (w_f_dir),
        .o_radius (w_f_r),
        .o_rr     (w_f_rr),
        .o_sq     (w_f_sq)
    );

    ssh_miss #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_miss (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_f_vld),
        .i_ctx    (w_f_ctx),
        .i_d      (w_f_d),
        .i_dir    (w_f_dir),
        .i_radius (w_f_r),
        .i_rr     (w_f_rr),
        .i_sq     (w_f_sq),
        .o_vld    (w_m_vld),
        .o_ctx    (w_m_ctx),
        .o_op     (w_m_op)
    );

    ssh_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_m_vld),
        .i_ctx   (w_m_ctx),
        .i_op    (w_m_op),
        .o_vld   (w_s_vld),
        .o_ctx   (w_s_ctx),
        .o_root  (w_s_root)
    );

    // entry distance and final result selection
    logic [LEN_W:0]   n_t;
    logic             n_hit;
    logic [LEN_W-1:0] n_dist;

    always_comb begin
        n_t    = {1'b0, w_s_ctx.proj} - {1'b0, w_s_root};
        n_hit  = 1'b0;
        n_dist = '0;
        case (w_s_ctx.kind)
            KIND_STATIC: begin
                n_hit  = 1'b1;
                n_dist = w_s_ctx.dist_mode ? w_s_root : '0;
            end
            KIND_SWEEP: begin
                n_hit = 1'b1;
                if (!n_t[LEN_W] && n_t[LEN_W-1:0] <= w_s_ctx.len) begin
                    n_dist = n_t[LEN_W-1:0];
                end
            end
            default: begin
                n_hit  = 1'b0;
                n_dist = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= n_hit;
        r_dist <= n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_s_vld;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;

    // a miss never carries a distance
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_hit |-> o_hit_distance == '0)
        else $error("miss result with nonzero distance");

    // strobe follows the last pipeline valid in the next cycle
    a_strobe_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_vld |=> o_strobe)
        else $error("result strobe lost");

    // static hit without distance reporting gives a zero distance
    a_static_nodist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_vld && w_s_ctx.kind == KIND_STATIC && !w_s_ctx.dist_mode
        |=> o_hit && o_hit_distance == '0)
        else $error("static hit reported a distance");

    // reset leaves no strobe behind
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

endmodule
